// File: hw/rtl/stack_bytecode_executor_core_defines.svh
// Assertion macros shared by the executor RTL.
// No dependencies.
`ifndef STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define SBE_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assert failed");
`else
`define SBE_ASSERT(label, clk, rst_n, prop)
`define SBE_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hw/rtl/sbe_pkg.sv
// Shared types, opcodes and error codes for the stack bytecode executor.
// No dependencies.
package sbe_pkg;
  localparam int WordW = 32;
  localparam int AddrW = 16;
  localparam int StackDepth = 256;
  localparam int SpW = $clog2(StackDepth);
  localparam int RegCount = 10;
  localparam int RegW = 4;

  localparam logic [7:0] OP_HLT = 8'd0;
  localparam logic [7:0] OP_PSH = 8'd1;
  localparam logic [7:0] OP_POP = 8'd2;
  localparam logic [7:0] OP_ADD = 8'd3;
  localparam logic [7:0] OP_MUL = 8'd4;
  localparam logic [7:0] OP_DIV = 8'd5;
  localparam logic [7:0] OP_SUB = 8'd6;
  localparam logic [7:0] OP_SLT = 8'd7;
  localparam logic [7:0] OP_MOV = 8'd8;
  localparam logic [7:0] OP_SET = 8'd9;
  localparam logic [7:0] OP_LOG = 8'd10;
  localparam logic [7:0] OP_IF  = 8'd11;
  localparam logic [7:0] OP_IFN = 8'd12;
  localparam logic [7:0] OP_GLD = 8'd13;
  localparam logic [7:0] OP_GPT = 8'd14;
  localparam logic [7:0] OP_NOP = 8'd15;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OVF   = 3'd1;
  localparam logic [2:0] ERR_UNF   = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_REG   = 3'd4;
  localparam logic [2:0] ERR_OPC   = 3'd5;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;
endpackage

// File: hw/rtl/stack_bytecode_executor_core.sv
// Stack bytecode executor top: sequencer, operand stack memory, register file.
// Depends on sbe_pkg, sbe_alu and the assertion macro header.
//
// Usage: one request on in_* carries an opcode and the three program words
// after it. The block executes it and presents one result on out_*.
// Config: cfg_we writes program_length (cfg_program_length); the user
// does so only while idle; the block itself does not enforce it.
// Steps: nop, branch, register and push/pop ops go from decode to result;
// gpt adds a stack read; slt, add, sub, mul and div read two entries from the
// single port stack; mul and div iterate one bit a cycle in the shared ALU.
// Throughput: one request at a time; in_ready is high only when idle
// and the result register is empty or being taken.
// Reset: registers zero, stack empty, instruction pointer zero,
// program_length 65535. Stack memory contents are not cleared.
// Stall: the result holds in the output register until out_ready; a new
// request is accepted in the cycle the result is taken.
`include "stack_bytecode_executor_core_defines.svh"
module stack_bytecode_executor_core
  import sbe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_program_length,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_kind,
  input  logic signed [31:0]      in_first_operand,
  input  logic signed [31:0]      in_second_operand,
  input  logic [15:0]             in_third_operand,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_next_address,
  output logic                    out_branch_taken,
  output logic                    out_log_valid,
  output logic signed [31:0]      out_log_value,
  output logic                    out_finished,
  output logic [2:0]              out_error_code
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [15:0]      plen_r;
  logic [7:0]       kind_r;
  logic [31:0]      op1_r, op2_r;
  logic [15:0]      tgt_r;
  logic [AddrW-1:0] ip_r, ip_nxt;
  logic [SpW:0]     depth_r, depth_nxt;
  logic             halted_r, halted_nxt;
  logic [WordW-1:0] gr_r [RegCount];
  logic [WordW-1:0] a_r, a_nxt;
  logic [WordW-1:0] b_r, b_nxt;
  logic [WordW-1:0] mem [StackDepth];
  logic [WordW-1:0] rd_r;
  logic [SpW-1:0]   rd_addr;
  logic             wr_en;
  logic [SpW-1:0]   wr_addr;
  logic [WordW-1:0] wr_data;
  logic             reg_we;
  logic [RegW-1:0]  reg_wa;
  logic [WordW-1:0] reg_wd;
  logic             abc_we;

  logic             ov_r, ov_nxt;
  logic [AddrW-1:0] o_next_r, o_next_nxt;
  logic             o_br_r, o_br_nxt;
  logic             o_lv_r, o_lv_nxt;
  logic [WordW-1:0] o_lval_r, o_lval_nxt;
  logic             o_fin_r, o_fin_nxt;
  logic [2:0]       o_err_r, o_err_nxt;

  alu_req_t  alu_req;
  alu_stat_t alu_stat;
  logic [WordW-1:0] alu_res;

  logic in_acc;
  logic r1_ok, r2_ok;
  logic [RegW-1:0] r1, r2;
  logic [WordW-1:0] g1;
  logic [SpW-1:0] top_idx;
  logic out_free;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign r1_ok    = op1_r < 32'(RegCount);
  assign r2_ok    = op2_r < 32'(RegCount);
  assign r1       = op1_r[RegW-1:0];
  assign r2       = op2_r[RegW-1:0];
  assign g1       = r1_ok ? gr_r[r1] : '0;
  assign top_idx  = SpW'(depth_r - 1'b1);

  sbe_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(alu_req), .b_in(b_r), .a_in(a_r),
    .stat(alu_stat), .result(alu_res)
  );

  always_comb begin
    st_nxt     = st_r;
    ip_nxt     = ip_r;
    depth_nxt  = depth_r;
    halted_nxt = halted_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rd_addr    = top_idx;
    wr_en      = 1'b0;
    wr_addr    = top_idx;
    wr_data    = '0;
    reg_we     = 1'b0;
    reg_wa     = r2;
    reg_wd     = '0;
    abc_we     = 1'b0;
    alu_req    = '0;
    ov_nxt     = ov_r && !out_ready;
    o_next_nxt = o_next_r;
    o_br_nxt   = o_br_r;
    o_lv_nxt   = o_lv_r;
    o_lval_nxt = o_lval_r;
    o_fin_nxt  = o_fin_r;
    o_err_nxt  = o_err_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = S_DEC;
      end
      S_DEC: begin
        st_nxt     = S_DONE;
        o_next_nxt = ip_r;
        o_br_nxt   = 1'b0;
        o_lv_nxt   = 1'b0;
        o_lval_nxt = '0;
        o_err_nxt  = ERR_NONE;
        if (halted_r || ip_r >= plen_r) begin
          o_fin_nxt = 1'b1;
        end else begin
          case (kind_r)
            OP_HLT: begin
              halted_nxt = 1'b1;
              o_next_nxt = ip_r + 1'b1;
            end
            OP_PSH, OP_GLD: begin
              if (kind_r == OP_GLD && !r1_ok) o_err_nxt = ERR_REG;
              else if (depth_r >= (SpW+1)'(StackDepth)) o_err_nxt = ERR_OVF;
              else begin
                wr_en      = 1'b1;
                wr_addr    = depth_r[SpW-1:0];
                wr_data    = (kind_r == OP_PSH) ? op1_r : g1;
                depth_nxt  = depth_r + 1'b1;
                o_next_nxt = ip_r + 2'd2;
              end
            end
            OP_POP: begin
              if (depth_r == '0) o_err_nxt = ERR_UNF;
              else begin
                depth_nxt  = depth_r - 1'b1;
                o_next_nxt = ip_r + 1'b1;
              end
            end
            OP_ADD, OP_MUL, OP_DIV, OP_SUB, OP_SLT: begin
              if (depth_r < (SpW+1)'(2)) o_err_nxt = ERR_UNF;
              else begin
                rd_addr = top_idx;
                st_nxt  = S_RDB;
              end
            end
            OP_MOV: begin
              if (!r1_ok || !r2_ok) o_err_nxt = ERR_REG;
              else begin
                reg_we     = 1'b1;
                reg_wa     = r2;
                reg_wd     = g1;
                o_next_nxt = ip_r + 2'd3;
              end
            end
            OP_SET: begin
              if (!r1_ok) o_err_nxt = ERR_REG;
              else begin
                reg_we     = 1'b1;
                reg_wa     = r1;
                reg_wd     = op2_r;
                o_next_nxt = ip_r + 2'd3;
              end
            end
            OP_LOG: begin
              if (!r1_ok) o_err_nxt = ERR_REG;
              else begin
                o_lv_nxt   = 1'b1;
                o_lval_nxt = g1;
                o_next_nxt = ip_r + 2'd2;
              end
            end
            OP_IF, OP_IFN: begin
              if (!r1_ok) o_err_nxt = ERR_REG;
              else if ((kind_r == OP_IF) == (g1 == op2_r)) begin
                o_next_nxt = tgt_r[AddrW-1:0];
                o_br_nxt   = 1'b1;
              end else o_next_nxt = ip_r + 3'd4;
            end
            OP_GPT: begin
              if (!r1_ok) o_err_nxt = ERR_REG;
              else if (depth_r == '0) o_err_nxt = ERR_UNF;
              else begin
                rd_addr = top_idx;
                st_nxt  = S_WAIT;
              end
            end
            OP_NOP: o_next_nxt = ip_r + 1'b1;
            default: o_err_nxt = ERR_OPC;
          endcase
        end
      end
      S_RDB: begin
        rd_addr = SpW'(depth_r - 2'd2);
        a_nxt   = rd_r;
        st_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (kind_r == OP_GPT) begin
          reg_we     = 1'b1;
          reg_wa     = r1;
          reg_wd     = rd_r;
          o_next_nxt = ip_r + 2'd2;
          st_nxt     = S_DONE;
        end else begin
          b_nxt = rd_r;
          if (kind_r == OP_DIV && a_r == '0) begin
            o_err_nxt = ERR_DIV0;
            st_nxt    = S_DONE;
          end else if (kind_r == OP_SLT) begin
            wr_en      = 1'b1;
            wr_addr    = SpW'(depth_r - 2'd2);
            wr_data    = WordW'($signed(a_r) < $signed(rd_r));
            depth_nxt  = depth_r - 1'b1;
            o_next_nxt = ip_r + 1'b1;
            st_nxt     = S_DONE;
          end else begin
            st_nxt = S_ALU;
          end
        end
      end
      S_ALU: begin
        if (!alu_stat.busy && !alu_stat.done) begin
          alu_req.start = 1'b1;
          case (kind_r)
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIV;
          endcase
        end
        if (alu_stat.done) begin
          wr_en      = 1'b1;
          wr_addr    = SpW'(depth_r - 2'd2);
          wr_data    = alu_res;
          abc_we     = 1'b1;
          depth_nxt  = depth_r - 1'b1;
          o_next_nxt = ip_r + 1'b1;
          st_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (o_err_r == ERR_NONE && !(halted_r && !o_fin_r && kind_r != OP_HLT))
            ip_nxt = o_next_r;
          o_fin_nxt = halted_r || (o_next_r >= plen_r);
          ov_nxt    = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      plen_r   <= 16'hFFFF;
      ip_r     <= '0;
      depth_r  <= '0;
      halted_r <= 1'b0;
      ov_r     <= 1'b0;
      o_fin_r  <= 1'b0;
      for (int i = 0; i < RegCount; i++) gr_r[i] <= '0;
    end else begin
      st_r     <= st_nxt;
      ip_r     <= ip_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
      ov_r     <= ov_nxt;
      o_fin_r  <= (st_r == S_DEC) ? 1'b0 : o_fin_nxt;
      if (cfg_we) plen_r <= cfg_program_length;
      if (reg_we) gr_r[reg_wa] <= reg_wd;
      if (abc_we) begin
        gr_r[0] <= a_r;
        gr_r[1] <= b_r;
        gr_r[2] <= alu_res;
      end
    end
    if (in_acc) begin
      kind_r <= in_kind;
      op1_r  <= in_first_operand;
      op2_r  <= in_second_operand;
      tgt_r  <= in_third_operand;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    o_next_r <= o_next_nxt;
    o_br_r   <= o_br_nxt;
    o_lv_r   <= o_lv_nxt;
    o_lval_r <= o_lval_nxt;
    o_err_r  <= o_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  assign out_valid        = ov_r;
  assign out_next_address = o_next_r;
  assign out_branch_taken = o_br_r;
  assign out_log_valid    = o_lv_r;
  assign out_log_value    = o_lval_r;
  assign out_finished     = o_fin_r;
  assign out_error_code   = o_err_r;

  `SBE_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> st_r == S_IDLE)
  `SBE_ASSERT(a_depth_max, clk, rst_n, depth_r <= (SpW+1)'(StackDepth))
  `SBE_ASSERT(a_err_holds_ip, clk, rst_n,
    (ov_r && o_err_r != ERR_NONE) |-> o_next_r == ip_r)
  `SBE_ASSERT_RST(a_reset_idle, clk, !$past(rst_n) |-> st_r == S_IDLE)
endmodule

// File: hw/rtl/sbe_alu.sv
// Shared multicycle arithmetic unit: add, sub, shift-add multiply, restoring divide.
// Depends on sbe_pkg.
`include "stack_bytecode_executor_core_defines.svh"
module sbe_alu
  import sbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [WordW-1:0] b_in,
  input  logic [WordW-1:0] a_in,
  output alu_stat_t        stat,
  output logic [WordW-1:0] result
);
  localparam int CntW = $clog2(WordW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WordW-1:0] acc_r, acc_nxt;
  logic [WordW-1:0] x_r, x_nxt;
  logic [WordW-1:0] y_r, y_nxt;
  logic             neg_r, neg_nxt;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rem_sh;

  assign rem_sh = {acc_r[WordW-2:0], x_r[WordW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(WordW);
      case (req.op)
        ALU_ADD: begin
          acc_nxt  = b_in + a_in;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          acc_nxt  = b_in - a_in;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          acc_nxt = '0;
          x_nxt   = b_in;
          y_nxt   = a_in;
        end
        default: begin
          acc_nxt = '0;
          x_nxt   = b_in[WordW-1] ? -b_in : b_in;
          y_nxt   = a_in[WordW-1] ? -a_in : a_in;
          neg_nxt = b_in[WordW-1] ^ a_in[WordW-1];
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (op_r == ALU_MUL) begin
        acc_nxt = acc_r + (y_r[0] ? x_r : '0);
        x_nxt   = x_r << 1;
        y_nxt   = y_r >> 1;
      end else begin
        x_nxt = {x_r[WordW-2:0], ~trial[WordW]};
        acc_nxt = trial[WordW] ? rem_sh : trial[WordW-1:0];
      end
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    case (op_r)
      ALU_DIV: result = neg_r ? -x_r : x_r;
      default: result = acc_r;
    endcase
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `SBE_ASSERT(a_no_start_busy, clk, rst_n, req.start |-> !busy_r)
  `SBE_ASSERT(a_not_both, clk, rst_n, !(busy_r && done_r))
  `SBE_ASSERT(a_fast_done, clk, rst_n,
    (req.start && (req.op == ALU_ADD || req.op == ALU_SUB)) |=> done_r)
endmodule
